[design/toroidal_life_generation_step_defines.svh]
// Assertion macros shared by the toroidal Life generation step design.
`ifndef TOROIDAL_LIFE_GENERATION_STEP_DEFINES_SVH
`define TOROIDAL_LIFE_GENERATION_STEP_DEFINES_SVH

`ifndef ASSERT_OFF
`define TLG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define TLG_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLG_ASSERT(lbl, prop, msg)
`define TLG_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[design/tlg_pkg.sv]
// Types, constants and helpers for the toroidal Life generation step.
package tlg_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int ADDR_W     = COL_W + ROW_W;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
	localparam int SIZE_W     = 7;
	localparam int CELL_W     = 2;

	// Row periods spent loading the window before the first row is computed.
	localparam logic [SIZE_W-1:0] PROLOGUE = SIZE_W'(3);
	localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(3);

	localparam logic [CELL_W-1:0] CELL_DEAD  = 2'd0;
	localparam logic [CELL_W-1:0] CELL_BORN  = 2'd1;
	localparam logic [CELL_W-1:0] CELL_ALIVE = 2'd2;
	localparam logic [CELL_W-1:0] CELL_DYING = 2'd3;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_STEP  = 2'd2,
		KIND_NONE  = 2'd3
	} tlg_kind_t;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} tlg_reg_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_GEN
	} tlg_state_t;

	// One column of the window: rows above, centre, below, and the row being loaded.
	typedef struct packed {
		logic [CELL_W-1:0] a;
		logic [CELL_W-1:0] b;
		logic [CELL_W-1:0] c;
		logic [CELL_W-1:0] d;
	} tlg_col_t;

	typedef struct packed {
		logic rotate;
		logic shift_d;
		logic transfer;
		logic from_s;
		logic save_s;
	} tlg_cell_ctrl_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
		input logic [SIZE_W-1:0] maxv);
		logic [SIZE_W-1:0] r;
		if (v < MIN_SIZE) begin
			r = MIN_SIZE;
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

[design/tlg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tlg_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/tlg_cell.sv]
// One column cell of the window chain: holds four rows of one column and a saved copy.
module tlg_cell (
	input  logic                        clk,
	input  tlg_pkg::tlg_cell_ctrl_t     ctrl,
	input  logic                        wrap,
	input  tlg_pkg::tlg_col_t           nxt,
	input  tlg_pkg::tlg_col_t           first,
	input  logic [tlg_pkg::CELL_W-1:0]  rdata,
	output tlg_pkg::tlg_col_t           col
);

	logic [tlg_pkg::CELL_W-1:0] a_q, b_q, c_q, d_q, s_q;
	logic [tlg_pkg::CELL_W-1:0] d_next;

	// The last active cell shifts in store data and rotates in the chain head, closing the ring.
	always_comb begin
		if (ctrl.shift_d) begin
			d_next = wrap ? rdata : nxt.d;
		end else begin
			d_next = d_q;
		end
	end

	always_ff @(posedge clk) begin
		d_q <= d_next;
		if (ctrl.rotate) begin
			a_q <= wrap ? first.a : nxt.a;
			b_q <= wrap ? first.b : nxt.b;
			c_q <= wrap ? first.c : nxt.c;
		end else if (ctrl.transfer) begin
			a_q <= b_q;
			b_q <= c_q;
			c_q <= ctrl.from_s ? s_q : d_next;
		end
		if (ctrl.transfer && ctrl.save_s) begin
			s_q <= d_next;
		end
	end

	assign col = '{a: a_q, b: b_q, c: c_q, d: d_q};

endmodule

[design/tlg_rule.sv]
// Counts the live neighbours of the centre cell and applies the four-state rule.
module tlg_rule (
	input  logic [tlg_pkg::CELL_W-1:0]       centre,
	input  logic [7:0][tlg_pkg::CELL_W-1:0]  nbr,
	output logic [tlg_pkg::CELL_W-1:0]       next_cell
);

	logic [3:0] count;
	logic       live;

	always_comb begin
		count = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (nbr[i] == tlg_pkg::CELL_BORN || nbr[i] == tlg_pkg::CELL_ALIVE) begin
				count = count + 4'd1;
			end
		end
	end

	assign live = (centre == tlg_pkg::CELL_BORN) || (centre == tlg_pkg::CELL_ALIVE);

	always_comb begin
		if ((centre == tlg_pkg::CELL_DEAD || centre == tlg_pkg::CELL_DYING)
			&& count == 4'd3) begin
			next_cell = tlg_pkg::CELL_BORN;
		end else if (centre == tlg_pkg::CELL_DYING) begin
			next_cell = tlg_pkg::CELL_DEAD;
		end else if (live && (count < 4'd2 || count > 4'd3)) begin
			next_cell = tlg_pkg::CELL_DYING;
		end else if (centre == tlg_pkg::CELL_BORN) begin
			next_cell = tlg_pkg::CELL_ALIVE;
		end else begin
			next_cell = centre;
		end
	end

endmodule

[design/toroidal_life_generation_step.sv]
// Top level of the toroidal Life generation step: grid store, window chain and control.
//
// Channel   Direction  Handshake             Payload
// s_        in         s_tvalid / s_tready   s_tuser kind; s_tdata column, row, new_cell
// m_        out        m_tvalid / m_tready   m_tdata cell_value
// cfg_      in         cfg_we                cfg_index, cfg_data
//
// After reset a clearing pass writes dead into all 4096 cells, one a cycle; no item
// is taken until it ends. A write item goes straight into the store; a read passes
// through the registered store read and the output register before its result is
// offered. A generation makes one store read per cell as rows stream into the
// column chain, with three extra row periods to fill the window. No item is taken
// during a generation, nor while a read result waits to move to m_.
`include "toroidal_life_generation_step_defines.svh"

module toroidal_life_generation_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // column [5:0], row [11:6], new_cell [13:12], zero pad
	input  logic [1:0]  s_tuser,   // kind [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // cell_value [1:0], zero pad
);

	localparam int SW = tlg_pkg::SIZE_W;
	localparam int CW = tlg_pkg::COL_W;
	localparam int RW = tlg_pkg::ROW_W;
	localparam int AW = tlg_pkg::ADDR_W;

	tlg_pkg::tlg_state_t state_q, state_d;

	logic [SW-1:0] width_q, height_q;
	logic [SW-1:0] w_eff, h_eff, w_m1, h_m1, h_p1, h_p2;
	logic [CW-1:0] wl;
	logic [RW-1:0] hl;

	logic [AW-1:0] clr_q;
	logic [SW-1:0] t_q, per_q;
	logic [RW-1:0] rrow_q, wrow_q;
	logic [CW-1:0] rcol;
	logic          rd_vld_s1;
	logic          rd_pend_q;
	logic          out_vld_q;
	logic [tlg_pkg::CELL_W-1:0] out_val_q;

	logic          accept;
	tlg_pkg::tlg_kind_t kind;
	logic [CW-1:0] column;
	logic [RW-1:0] row;
	logic [tlg_pkg::CELL_W-1:0] new_cell;

	logic          in_row, period_end, computing, gen_done, out_load;

	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [tlg_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

	tlg_pkg::tlg_cell_ctrl_t cell_ctrl;
	tlg_pkg::tlg_col_t       cols [tlg_pkg::MAX_WIDTH];
	logic [7:0][tlg_pkg::CELL_W-1:0] nbr;
	logic [tlg_pkg::CELL_W-1:0] rule_out;

	assign kind     = tlg_pkg::tlg_kind_t'(s_tuser);
	assign column   = s_tdata[5:0];
	assign row      = s_tdata[11:6];
	assign new_cell = s_tdata[13:12];
	assign accept   = s_tvalid && s_tready;

	// Sizes in use, clamped to the range the grid supports.
	assign w_eff = tlg_pkg::clamp_size(width_q, SW'(tlg_pkg::MAX_WIDTH));
	assign h_eff = tlg_pkg::clamp_size(height_q, SW'(tlg_pkg::MAX_HEIGHT));
	assign w_m1  = w_eff - SW'(1);
	assign h_m1  = h_eff - SW'(1);
	assign h_p1  = h_eff + SW'(1);
	assign h_p2  = h_eff + SW'(2);
	assign wl    = w_m1[CW-1:0];
	assign hl    = h_m1[RW-1:0];

	assign in_row     = (state_q == tlg_pkg::ST_GEN) && (t_q < w_eff);
	assign period_end = (state_q == tlg_pkg::ST_GEN) && (t_q == w_eff);
	assign computing  = per_q >= tlg_pkg::PROLOGUE;
	assign gen_done   = period_end && (per_q == h_p2);
	// Columns are fetched starting with the last one so that cell 1 holds column 0.
	assign rcol       = (t_q == '0) ? wl : (t_q[CW-1:0] - CW'(1));
	assign out_load   = rd_pend_q && (!out_vld_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SW'(tlg_pkg::MAX_WIDTH);
			height_q <= SW'(tlg_pkg::MAX_HEIGHT);
		end else if (cfg_we) begin
			case (tlg_pkg::tlg_reg_t'(cfg_index))
				tlg_pkg::REG_WIDTH: begin
					width_q <= cfg_data;
				end
				tlg_pkg::REG_HEIGHT: begin
					height_q <= cfg_data;
				end
				default: begin
					width_q <= width_q;
				end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tlg_pkg::ST_CLEAR: begin
				if (clr_q == '1) begin
					state_d = tlg_pkg::ST_IDLE;
				end
			end
			tlg_pkg::ST_IDLE: begin
				if (accept && kind == tlg_pkg::KIND_STEP) begin
					state_d = tlg_pkg::ST_GEN;
				end
			end
			tlg_pkg::ST_GEN: begin
				if (gen_done) begin
					state_d = tlg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tlg_pkg::ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = tlg_pkg::CELL_DEAD;
		ram_re    = 1'b0;
		ram_raddr = {row, column};
		cell_ctrl = '0;
		case (state_q)
			tlg_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			tlg_pkg::ST_IDLE: begin
				s_tready  = !rd_pend_q;
				ram_we    = accept && kind == tlg_pkg::KIND_WRITE;
				ram_waddr = {row, column};
				ram_wdata = new_cell;
				ram_re    = accept && kind == tlg_pkg::KIND_READ;
			end
			tlg_pkg::ST_GEN: begin
				ram_we    = in_row && computing;
				ram_waddr = {wrow_q, t_q[CW-1:0]};
				ram_wdata = rule_out;
				ram_re    = in_row;
				ram_raddr = {rrow_q, rcol};
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
		cell_ctrl.rotate   = in_row;
		cell_ctrl.shift_d  = rd_vld_s1;
		cell_ctrl.transfer = period_end;
		// The last row needs the old top row as its lower neighbour; the store
		// already holds the new one by then, so the saved copy is used.
		cell_ctrl.from_s   = per_q == h_p1;
		cell_ctrl.save_s   = per_q == SW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tlg_pkg::ST_CLEAR;
			clr_q     <= '0;
			t_q       <= '0;
			per_q     <= '0;
			rrow_q    <= '0;
			wrow_q    <= '0;
			rd_vld_s1 <= 1'b0;
			rd_pend_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= in_row;
			if (state_q == tlg_pkg::ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (state_q == tlg_pkg::ST_IDLE && state_d == tlg_pkg::ST_GEN) begin
				t_q    <= '0;
				per_q  <= '0;
				rrow_q <= hl;
				wrow_q <= '0;
			end else if (period_end) begin
				t_q    <= '0;
				per_q  <= per_q + SW'(1);
				rrow_q <= (rrow_q == hl) ? '0 : rrow_q + RW'(1);
				if (computing) begin
					wrow_q <= wrow_q + RW'(1);
				end
			end else if (in_row) begin
				t_q <= t_q + SW'(1);
			end
			if (out_load) begin
				rd_pend_q <= 1'b0;
				out_vld_q <= 1'b1;
			end else begin
				if (accept && kind == tlg_pkg::KIND_READ) begin
					rd_pend_q <= 1'b1;
				end
				if (m_tready) begin
					out_vld_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_val_q <= ram_rdata;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {6'd0, out_val_q};

	tlg_ram #(
		.WIDTH (tlg_pkg::CELL_W),
		.DEPTH (tlg_pkg::DEPTH)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	for (genvar j = 0; j < tlg_pkg::MAX_WIDTH; j++) begin : g_cell
		tlg_cell u_cell (
			.clk   (clk),
			.ctrl  (cell_ctrl),
			.wrap  (CW'(j) == wl),
			.nxt   (cols[(j + 1) % tlg_pkg::MAX_WIDTH]),
			.first (cols[0]),
			.rdata (ram_rdata),
			.col   (cols[j])
		);
	end

	// Cell 1 holds the column being computed, cells 0 and 2 its left and right.
	assign nbr = {cols[0].a, cols[1].a, cols[2].a, cols[0].b,
		cols[2].b, cols[0].c, cols[1].c, cols[2].c};

	tlg_rule u_rule (
		.centre    (cols[1].b),
		.nbr       (nbr),
		.next_cell (rule_out)
	);

	`TLG_ASSERT(a_gen_write_after_fill, (state_q == tlg_pkg::ST_GEN && ram_we) |-> computing, "generation wrote the store before the window was filled")
	`TLG_ASSERT(a_read_moves_out, out_load |=> (out_vld_q && !rd_pend_q), "read result did not reach the output register")
	`TLG_ASSERT(a_clear_to_idle, (state_q == tlg_pkg::ST_CLEAR && clr_q == '1) |=> (state_q == tlg_pkg::ST_IDLE && !out_vld_q), "clearing pass did not end in idle")
	`TLG_ASSERT_ALWAYS(a_no_accept_in_reset, !arst_n |-> !s_tready, "input accepted while in reset")

endmodule

[dv/tb.sv]
// Self-checking testbench for the toroidal Life generation step, with grid predictor.
`timescale 1ns / 1ps

module tb;

	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_PHASES = 7;
	localparam int OPS_PER_PHASE = 17;

	typedef struct {
		tlg_pkg::tlg_kind_t kind;
		logic [5:0] col;
		logic [5:0] row;
		logic [1:0] state_val;
	} grid_op_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [6:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;   // column [5:0], row [11:6], new_cell [13:12], zero pad
	logic [1:0]  s_tuser;   // kind [1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // cell_value [1:0], zero pad

	// Predicted grid and size registers.
	logic [1:0] life_grid [tlg_pkg::MAX_HEIGHT][tlg_pkg::MAX_WIDTH];
	logic [6:0] width_reg;
	logic [6:0] height_reg;

	grid_op_t   pending_ops [$];
	logic [1:0] expected_cells [$];
	grid_op_t   next_op;
	int         ops_queued;
	int         ops_taken;
	int         err_count;
	int         cycle_count;
	int         send_idle;
	int         recv_idle;
	bit         in_fire;

	toroidal_life_generation_step dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int active_size(input logic [6:0] v);
		if (v < 7'd3) begin
			return 3;
		end else if (v > 7'd64) begin
			return 64;
		end
		return int'(v);
	endfunction

	function automatic int is_live(input logic [1:0] s);
		return (s == tlg_pkg::CELL_BORN || s == tlg_pkg::CELL_ALIVE) ? 1 : 0;
	endfunction

	function automatic void advance_generation();
		logic [1:0] prev [tlg_pkg::MAX_HEIGHT][tlg_pkg::MAX_WIDTH];
		int w;
		int h;
		int up;
		int dn;
		int lf;
		int rt;
		int n;
		logic [1:0] s;
		logic [1:0] ns;
		prev = life_grid;
		w = active_size(width_reg);
		h = active_size(height_reg);
		for (int r = 0; r < h; r++) begin
			up = (r + 1) % h;
			dn = (r + h - 1) % h;
			for (int c = 0; c < w; c++) begin
				lf = (c + w - 1) % w;
				rt = (c + 1) % w;
				n = is_live(prev[up][lf]) + is_live(prev[up][c]) + is_live(prev[up][rt])
					+ is_live(prev[r][lf]) + is_live(prev[r][rt])
					+ is_live(prev[dn][lf]) + is_live(prev[dn][c]) + is_live(prev[dn][rt]);
				s = prev[r][c];
				ns = s;
				if ((s == tlg_pkg::CELL_DEAD || s == tlg_pkg::CELL_DYING) && n == 3) begin
					ns = tlg_pkg::CELL_BORN;
				end else if (s == tlg_pkg::CELL_DYING) begin
					ns = tlg_pkg::CELL_DEAD;
				end else if (is_live(s) == 1 && (n < 2 || n > 3)) begin
					ns = tlg_pkg::CELL_DYING;
				end else if (s == tlg_pkg::CELL_BORN) begin
					ns = tlg_pkg::CELL_ALIVE;
				end
				life_grid[r][c] = ns;
			end
		end
	endfunction

	task automatic push_grid_op(input tlg_pkg::tlg_kind_t kind, input int col, input int row,
		input logic [1:0] state_val);
		grid_op_t op;
		op.kind = kind;
		op.col = col[5:0];
		op.row = row[5:0];
		op.state_val = state_val;
		pending_ops.push_back(op);
		ops_queued++;
	endtask

	task automatic set_idle_mode(input int phase);
		if (phase < 3) begin
			send_idle = 7;
			recv_idle = 75;
		end else if (phase < 6) begin
			send_idle = 75;
			recv_idle = 7;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
	endtask

	task automatic write_size_reg(input tlg_pkg::tlg_reg_t idx, input logic [6:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == tlg_pkg::REG_WIDTH) begin
			width_reg = v;
		end else begin
			height_reg = v;
		end
	endtask

	// Holds off until every item is taken and answered, then lets a full generation
	// at the current size run out, since an advance gives no result to wait for.
	task automatic drain_and_settle();
		while (pending_ops.size() != 0 || ops_taken != ops_queued
			|| expected_cells.size() != 0) begin
			@(posedge clk);
		end
		repeat ((active_size(height_reg) + 3) * (active_size(width_reg) + 1) + 16)
			@(posedge clk);
	endtask

	task automatic queue_random_ops(input int count);
		int w;
		int h;
		int r;
		grid_op_t op;
		w = active_size(width_reg);
		h = active_size(height_reg);
		for (int i = 0; i < count; i++) begin
			// Each phase opens with a few writes so that advances have a pattern to work on.
			r = (i < 5) ? 0 : int'($urandom_range(99));
			op.col = 6'($urandom_range(63));
			op.row = 6'($urandom_range(63));
			op.state_val = 2'($urandom_range(3));
			if ($urandom_range(99) < 85) begin
				op.col = 6'($urandom_range(w - 1));
				op.row = 6'($urandom_range(h - 1));
			end
			if (r < 45) begin
				op.kind = tlg_pkg::KIND_WRITE;
			end else if (r < 80) begin
				op.kind = tlg_pkg::KIND_READ;
			end else if (r < 92) begin
				op.kind = tlg_pkg::KIND_STEP;
			end else begin
				op.kind = tlg_pkg::KIND_NONE;
			end
			pending_ops.push_back(op);
			ops_queued++;
		end
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("toroidal_life_generation_step verification failed");
			$finish;
		end
	end

	// Input acceptance drives the predictor; results are checked in arrival order.
	always @(posedge clk) begin
		in_fire = arst_n && s_tvalid && s_tready;
		if (in_fire) begin
			ops_taken++;
			case (tlg_pkg::tlg_kind_t'(s_tuser))
				tlg_pkg::KIND_WRITE: life_grid[s_tdata[11:6]][s_tdata[5:0]] = s_tdata[13:12];
				tlg_pkg::KIND_READ:
					expected_cells.push_back(life_grid[s_tdata[11:6]][s_tdata[5:0]]);
				tlg_pkg::KIND_STEP:  advance_generation();
				default: ;
			endcase
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_cells.size() == 0) begin
				err_count++;
				$display("%0t: cell value %0d arrived with none expected", $time,
					m_tdata[1:0]);
			end else if (m_tdata[1:0] !== expected_cells[0]) begin
				err_count++;
				$display("%0t: cell value expected %0d, actual %0d", $time,
					expected_cells[0], m_tdata[1:0]);
				void'(expected_cells.pop_front());
			end else begin
				void'(expected_cells.pop_front());
			end
		end
	end

	always @(negedge clk) begin
		if (!s_tvalid || in_fire) begin
			if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle) begin
				next_op = pending_ops.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= next_op.kind;
				s_tdata <= {2'b00, next_op.state_val, next_op.row, next_op.col};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	initial begin
		logic [6:0] phase_width [RANDOM_PHASES];
		logic [6:0] phase_height [RANDOM_PHASES];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = 7'd0;
		s_tvalid = 1'b0;
		s_tdata = 16'd0;
		s_tuser = 2'd0;
		m_tready = 1'b0;
		width_reg = 7'd64;
		height_reg = 7'd64;
		for (int r = 0; r < tlg_pkg::MAX_HEIGHT; r++) begin
			for (int c = 0; c < tlg_pkg::MAX_WIDTH; c++) begin
				life_grid[r][c] = tlg_pkg::CELL_DEAD;
			end
		end
		phase_width  = '{7'd3, 7'd0,   7'd127, 7'd5, 7'd64, 7'd8, 7'd3};
		phase_height = '{7'd3, 7'd127, 7'd2,   7'd7, 7'd4,  7'd6, 7'd3};
		phase_width[6] = 7'($urandom_range(12, 3));
		phase_height[6] = 7'($urandom_range(12, 3));
		set_idle_mode(0);
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Full 64 by 64 grid: a blinker and two dying cells across the wrap, and other single cells.
		push_grid_op(tlg_pkg::KIND_WRITE, 0, 0, tlg_pkg::CELL_ALIVE);
		push_grid_op(tlg_pkg::KIND_WRITE, 63, 0, tlg_pkg::CELL_BORN);
		push_grid_op(tlg_pkg::KIND_WRITE, 1, 0, tlg_pkg::CELL_ALIVE);
		push_grid_op(tlg_pkg::KIND_WRITE, 0, 63, tlg_pkg::CELL_DYING);
		push_grid_op(tlg_pkg::KIND_WRITE, 0, 1, tlg_pkg::CELL_DYING);
		push_grid_op(tlg_pkg::KIND_WRITE, 40, 40, tlg_pkg::CELL_ALIVE);
		push_grid_op(tlg_pkg::KIND_WRITE, 41, 41, tlg_pkg::CELL_DYING);
		push_grid_op(tlg_pkg::KIND_WRITE, 63, 63, tlg_pkg::CELL_BORN);
		push_grid_op(tlg_pkg::KIND_WRITE, 2, 2, tlg_pkg::CELL_DEAD);
		push_grid_op(tlg_pkg::KIND_READ, 63, 63, tlg_pkg::CELL_DEAD);
		push_grid_op(tlg_pkg::KIND_READ, 0, 63, tlg_pkg::CELL_DEAD);
		push_grid_op(tlg_pkg::KIND_READ, 20, 20, tlg_pkg::CELL_DEAD);
		push_grid_op(tlg_pkg::KIND_NONE, 63, 63, tlg_pkg::CELL_DYING);
		push_grid_op(tlg_pkg::KIND_READ, 63, 63, tlg_pkg::CELL_DYING);
		push_grid_op(tlg_pkg::KIND_STEP, 63, 63, tlg_pkg::CELL_DYING);
		push_grid_op(tlg_pkg::KIND_READ, 0, 0, tlg_pkg::CELL_DEAD);
		push_grid_op(tlg_pkg::KIND_READ, 63, 0, tlg_pkg::CELL_DEAD);
		push_grid_op(tlg_pkg::KIND_READ, 1, 0, tlg_pkg::CELL_DEAD);
		push_grid_op(tlg_pkg::KIND_READ, 0, 63, tlg_pkg::CELL_DEAD);
		push_grid_op(tlg_pkg::KIND_READ, 0, 1, tlg_pkg::CELL_DEAD);
		push_grid_op(tlg_pkg::KIND_READ, 40, 40, tlg_pkg::CELL_DEAD);
		push_grid_op(tlg_pkg::KIND_READ, 41, 41, tlg_pkg::CELL_DEAD);
		push_grid_op(tlg_pkg::KIND_READ, 63, 63, tlg_pkg::CELL_DEAD);
		push_grid_op(tlg_pkg::KIND_READ, 2, 2, tlg_pkg::CELL_DEAD);
		drain_and_settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			set_idle_mode(p + 1);
			write_size_reg(tlg_pkg::REG_WIDTH, phase_width[p]);
			write_size_reg(tlg_pkg::REG_HEIGHT, phase_height[p]);
			queue_random_ops(OPS_PER_PHASE);
			drain_and_settle();
		end

		if (err_count == 0) begin
			$display("toroidal_life_generation_step verification clean");
		end else begin
			$display("toroidal_life_generation_step verification failed");
		end
		$finish;
	end

endmodule
